FILE: rtl/core/mccd_pkg.sv
// Shared constants, payload types and controller states of the minimum coin change block.
package mccd_pkg;

	localparam int FIELD_W = 10;
	localparam int COUNT_W = 11;
	localparam logic [COUNT_W-1:0] COUNT_INF = '1;
	localparam int MAX_AMOUNT_DEF = 1023;

	typedef struct packed {
		logic [FIELD_W-1:0] coin_value;
		logic [FIELD_W-1:0] target_amount;
		logic               last_coin;
	} coin_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] min_coins;
		logic               unreachable;
	} result_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SWEEP,
		ST_DRAIN,
		ST_FETCH,
		ST_RESULT
	} state_t;

endpackage

FILE: rtl/core/mccd_stream_if.sv
// Valid/ready channel that carries one payload item per transfer.
interface mccd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/min_coin_change_dp.sv
// Minimum coin change engine over a one-row table of best counts held in a dual-read RAM.
// Per coin item, accepted in idle: with T the held target and C the coin, a problem's first
// item clears entries 0..T, the sweep updates entries C..T and a drain state finishes the
// read-modify-write stage (no sweep for a zero coin or C above T), and a last coin fetches
// and registers the result, holding in the result state while the last result waits.
// Reset clears the controller, the held target and the open-problem flag; the table is not swept.
module min_coin_change_dp #(
	parameter int MAX_AMOUNT = mccd_pkg::MAX_AMOUNT_DEF
) (
	input logic           clk,
	input logic           arst_n,
	mccd_stream_if.sink   coin,
	mccd_stream_if.source result
);

	localparam int DEPTH = MAX_AMOUNT + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = mccd_pkg::COUNT_W;
	localparam int FW = mccd_pkg::FIELD_W;

	mccd_pkg::state_t state_q, state_d;

	logic [AW-1:0] held_target_q;
	logic          open_q;
	logic [FW-1:0] coin_q;
	logic          last_q;
	logic [AW-1:0] clr_idx_q;
	logic [AW-1:0] j_q;
	logic          sweep_v_s1;
	logic [AW-1:0] rda_s1;
	logic [AW-1:0] rdb_s1;
	logic          fwd_v_q;
	logic [AW-1:0] fwd_addr_q;
	logic [CW-1:0] fwd_data_q;
	logic          out_valid_q;
	mccd_pkg::result_item_t result_q;

	logic          accept;
	logic          coin_ok_in;
	logic          coin_ok_q;
	logic [AW-1:0] target_sat;
	logic [AW-1:0] coin_aw;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] wr_data;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;
	logic [CW-1:0] ram_a;
	logic [CW-1:0] ram_b;
	logic [CW-1:0] a_val;
	logic [CW-1:0] b_val;
	logic [CW-1:0] cand;
	logic [CW-1:0] upd_val;
	logic          capture;

	assign accept = coin.valid && coin.ready;
	assign target_sat = (32'(coin.data.target_amount) > MAX_AMOUNT) ?
		AW'(MAX_AMOUNT) : AW'(coin.data.target_amount);
	assign coin_ok_in = (coin.data.coin_value != '0) &&
		(32'(coin.data.coin_value) <= 32'(held_target_q));
	assign coin_ok_q = (coin_q != '0) && (32'(coin_q) <= 32'(held_target_q));
	assign coin_aw = AW'(coin_q);

	mccd_ram #(
		.WIDTH(CW),
		.DEPTH(DEPTH)
	) u_row (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr_a(rd_addr_a),
		.rd_data_a(ram_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_b(ram_b)
	);

	// The RAM returns old data when a read meets a write at the same edge.
	assign a_val = (fwd_v_q && fwd_addr_q == rda_s1) ? fwd_data_q : ram_a;
	assign b_val = (fwd_v_q && fwd_addr_q == rdb_s1) ? fwd_data_q : ram_b;
	assign cand = (a_val == mccd_pkg::COUNT_INF) ? mccd_pkg::COUNT_INF : a_val + CW'(1);
	assign upd_val = (cand < b_val) ? cand : b_val;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mccd_pkg::ST_IDLE: begin
				if (accept) begin
					if (!open_q) begin
						state_d = mccd_pkg::ST_CLEAR;
					end else if (coin_ok_in) begin
						state_d = mccd_pkg::ST_SWEEP;
					end else if (coin.data.last_coin) begin
						state_d = mccd_pkg::ST_FETCH;
					end
				end
			end
			mccd_pkg::ST_CLEAR: begin
				if (clr_idx_q == held_target_q) begin
					if (coin_ok_q) begin
						state_d = mccd_pkg::ST_SWEEP;
					end else if (last_q) begin
						state_d = mccd_pkg::ST_FETCH;
					end else begin
						state_d = mccd_pkg::ST_IDLE;
					end
				end
			end
			mccd_pkg::ST_SWEEP: begin
				if (j_q == held_target_q) begin
					state_d = mccd_pkg::ST_DRAIN;
				end
			end
			mccd_pkg::ST_DRAIN: begin
				state_d = last_q ? mccd_pkg::ST_FETCH : mccd_pkg::ST_IDLE;
			end
			mccd_pkg::ST_FETCH: begin
				state_d = mccd_pkg::ST_RESULT;
			end
			mccd_pkg::ST_RESULT: begin
				if (capture) begin
					state_d = mccd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mccd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		coin.ready = 1'b0;
		capture = 1'b0;
		rd_addr_a = j_q - coin_aw;
		rd_addr_b = j_q;
		wr_en = sweep_v_s1;
		wr_addr = rdb_s1;
		wr_data = upd_val;
		unique case (state_q)
			mccd_pkg::ST_IDLE: begin
				coin.ready = 1'b1;
			end
			mccd_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_idx_q;
				wr_data = (clr_idx_q == '0) ? '0 : mccd_pkg::COUNT_INF;
			end
			mccd_pkg::ST_FETCH: begin
				rd_addr_a = held_target_q;
			end
			mccd_pkg::ST_RESULT: begin
				rd_addr_a = held_target_q;
				capture = !out_valid_q || result.ready;
			end
			mccd_pkg::ST_SWEEP, mccd_pkg::ST_DRAIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mccd_pkg::ST_IDLE;
			held_target_q <= '0;
			open_q <= 1'b0;
			sweep_v_s1 <= 1'b0;
			fwd_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_v_s1 <= (state_q == mccd_pkg::ST_SWEEP);
			if (wr_en) begin
				fwd_v_q <= 1'b1;
			end
			if (accept && !open_q) begin
				held_target_q <= target_sat;
				open_q <= 1'b1;
			end
			if (capture) begin
				open_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rda_s1 <= rd_addr_a;
		rdb_s1 <= rd_addr_b;
		if (wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
		if (accept) begin
			coin_q <= coin.data.coin_value;
			last_q <= coin.data.last_coin;
			j_q <= AW'(coin.data.coin_value);
			clr_idx_q <= '0;
		end else begin
			if (state_q == mccd_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + AW'(1);
			end
			if (state_q == mccd_pkg::ST_SWEEP) begin
				j_q <= j_q + AW'(1);
			end
		end
		if (capture) begin
			if (a_val == mccd_pkg::COUNT_INF) begin
				result_q.min_coins <= '0;
				result_q.unreachable <= 1'b1;
			end else begin
				result_q.min_coins <= a_val[FW-1:0];
				result_q.unreachable <= 1'b0;
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.data = result_q;

	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.unreachable |-> result_q.min_coins == '0)
		else $error("unreachable result carries a nonzero count");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wr_addr <= held_target_q)
		else $error("row write beyond the held target");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mccd_pkg::ST_SWEEP |-> j_q <= held_target_q && j_q >= coin_aw)
		else $error("sweep index outside the coin to target range");

	a_new_problem_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !open_q |=> state_q == mccd_pkg::ST_CLEAR)
		else $error("first coin of a problem did not start a clear");

endmodule

FILE: rtl/core/mccd_ram.sv
// Generic single-write, dual-read memory with registered read data.
module mccd_ram #(
	parameter int WIDTH = mccd_pkg::COUNT_W,
	parameter int DEPTH = mccd_pkg::MAX_AMOUNT_DEF + 1
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic [WIDTH-1:0]         rd_data_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule
